// ===== design/ola_pkg.sv =====
// Shared types and codes for the ordered array list.
`timescale 1ns / 1ps
`default_nettype none

package ola_pkg;

	localparam int KINDW = 3;
	localparam int IDXW  = 7;
	localparam int WORDW = 32;
	localparam int STW   = 2;
	localparam int CNTW  = 7;

	// operation codes on the request beat
	localparam logic [KINDW-1:0] KIND_PUSH   = 3'd0;
	localparam logic [KINDW-1:0] KIND_POP    = 3'd1;
	localparam logic [KINDW-1:0] KIND_GET    = 3'd2;
	localparam logic [KINDW-1:0] KIND_INSERT = 3'd3;
	localparam logic [KINDW-1:0] KIND_REMOVE = 3'd4;

	// result status codes
	localparam logic [STW-1:0] ST_OK    = 2'd0;
	localparam logic [STW-1:0] ST_RANGE = 2'd1;
	localparam logic [STW-1:0] ST_EMPTY = 2'd2;
	localparam logic [STW-1:0] ST_FULL  = 2'd3;

	typedef struct packed {
		logic [KINDW-1:0]        kind;
		logic [IDXW-1:0]         index;
		logic signed [WORDW-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [WORDW-1:0] read_value;
		logic [STW-1:0]          status;
		logic [CNTW-1:0]         count;
	} rsp_t;

	// what every cell does on a given cycle
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_PUSH,
		OP_INS,
		OP_REM
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     at;     // cell sits at the target position
		logic     above;  // cell sits beyond the target position
		logic     rd;     // cell drives its word onto the read tree
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== design/ola_cell.sv =====
// One storage cell of the list: holds a word, shifts with its neighbours.
`timescale 1ns / 1ps
`default_nettype none

module ola_cell (
	input  logic                     clk,
	input  ola_pkg::cell_ctl_t       ctl,
	input  logic [ola_pkg::WORDW-1:0] value,
	input  logic [ola_pkg::WORDW-1:0] left,
	input  logic [ola_pkg::WORDW-1:0] right,
	output logic [ola_pkg::WORDW-1:0] data,
	output logic [ola_pkg::WORDW-1:0] hit
);
	import ola_pkg::*;

	logic [WORDW-1:0] data_q;
	logic [WORDW-1:0] data_d;

	always_comb begin
		data_d = data_q;
		case (ctl.op)
			OP_PUSH: begin
				if (ctl.at) begin
					data_d = value;
				end
			end
			OP_INS: begin
				if (ctl.at) begin
					data_d = value;
				end else if (ctl.above) begin
					data_d = left;
				end
			end
			OP_REM: begin
				if (ctl.at || ctl.above) begin
					data_d = right;
				end
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;
	assign hit  = ctl.rd ? data_q : '0;

endmodule

`default_nettype wire

// ===== design/ola_rdtree.sv =====
// Registered two-level OR tree collecting the one selected cell word.
`timescale 1ns / 1ps
`default_nettype none

module ola_rdtree #(
	parameter int DEPTH = 64
) (
	input  logic                                 clk,
	input  logic                                 load,
	input  logic [DEPTH-1:0][ola_pkg::WORDW-1:0] hit,
	output logic [ola_pkg::WORDW-1:0]            word
);
	import ola_pkg::*;

	// group size about the square root of the depth, so both levels stay narrow
	localparam int GB   = ($clog2(DEPTH) + 1) / 2;
	localparam int GSZ  = 1 << GB;
	localparam int NGRP = (DEPTH + GSZ - 1) / GSZ;

	logic [NGRP-1:0][WORDW-1:0] grp_d;
	logic [NGRP-1:0][WORDW-1:0] grp_s1;

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = '0;
			for (int j = 0; j < GSZ; j++) begin
				if (g * GSZ + j < DEPTH) begin
					grp_d[g] = grp_d[g] | hit[g * GSZ + j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grp_s1 <= grp_d;
		end
	end

	always_comb begin
		word = '0;
		for (int g = 0; g < NGRP; g++) begin
			word = word | grp_s1[g];
		end
	end

endmodule

`default_nettype wire

// ===== design/ordered_array_list.sv =====
// Ordered array list top level: control, row of register cells, read tree, result register.
// A taken request goes into the read stage register, then into the result register.
// One request per cycle unless stalled; insert and remove shift every later cell at once.
// The request side stalls only while a finished result waits and the read stage behind it is full.
// Reset clears the element count and all pipeline valids; cell contents are not cleared,
// and only cells below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module ordered_array_list #(
	parameter int DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ola_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ola_pkg::rsp_t rsp
);
	import ola_pkg::*;

	localparam int AW = $clog2(DEPTH);       // cell address
	localparam int CW = $clog2(DEPTH + 1);   // element count, 0..DEPTH
	localparam int XW = (CW > IDXW) ? CW : IDXW;

	// list state
	logic [CW-1:0] count_q;

	// request decode
	logic          acc;
	logic [XW-1:0] n_x;
	logic [XW-1:0] i_x;
	logic [XW-1:0] nm1_x;
	logic [XW-1:0] cnt_x;
	logic          full;
	logic          empty;
	cell_op_t      op_d;
	logic [AW-1:0] pos_d;
	logic          rd_en_d;
	logic [AW-1:0] rd_addr_d;
	logic [STW-1:0] status_d;
	logic [CW-1:0] cnt_d;

	// read stage and result register
	logic           s1_vld_q;
	logic [STW-1:0] status_s1;
	logic [CNTW-1:0] count_s1;
	logic           advance;
	logic           rsp_vld_q;
	rsp_t           rsp_q;

	// cell row
	cell_ctl_t [DEPTH-1:0]              ctl;
	logic [DEPTH-1:0][WORDW-1:0]        cell_data;
	logic [DEPTH-1:0][WORDW-1:0]        cell_hit;
	logic [WORDW-1:0]                   tree_word;

	assign n_x   = XW'(count_q);
	assign i_x   = XW'(req.index);
	assign nm1_x = n_x - XW'(1);
	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	// Each operation picks a cell op, a target position and an optional read.
	// Flagged requests leave the row and the count alone.
	always_comb begin
		op_d      = OP_HOLD;
		pos_d     = n_x[AW-1:0];
		rd_en_d   = 1'b0;
		rd_addr_d = i_x[AW-1:0];
		status_d  = ST_OK;
		cnt_d     = count_q;
		case (req.kind)
			KIND_PUSH: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					op_d  = OP_PUSH;
					cnt_d = count_q + CW'(1);
				end
			end
			KIND_POP: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					rd_en_d   = 1'b1;
					rd_addr_d = nm1_x[AW-1:0];
					cnt_d     = count_q - CW'(1);
				end
			end
			KIND_GET: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else if (i_x >= n_x) begin
					status_d = ST_RANGE;
				end else begin
					rd_en_d = 1'b1;
				end
			end
			KIND_INSERT: begin
				// full takes precedence over a bad index; index equal to count appends
				if (full) begin
					status_d = ST_FULL;
				end else if (i_x > n_x) begin
					status_d = ST_RANGE;
				end else begin
					op_d  = OP_INS;
					pos_d = i_x[AW-1:0];
					cnt_d = count_q + CW'(1);
				end
			end
			KIND_REMOVE: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else if (i_x >= n_x) begin
					status_d = ST_RANGE;
				end else begin
					rd_en_d = 1'b1;
					op_d    = OP_REM;
					pos_d   = i_x[AW-1:0];
					cnt_d   = count_q - CW'(1);
				end
			end
			default: begin
				// unknown kinds: no change, status ok, read value zero
				op_d = OP_HOLD;
			end
		endcase
	end

	assign cnt_x = XW'(cnt_d);

	// Handshake: the read stage moves on when the result register is free or being drained.
	assign advance   = s1_vld_q && (!rsp_vld_q || !rsp_stall);
	assign req_stall = s1_vld_q && !advance;
	assign acc       = req_valid && !req_stall;

	// The row: every cell compares its own position against the broadcast target.
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		localparam logic [AW-1:0] POS = AW'(k);
		logic [WORDW-1:0] left_w;
		logic [WORDW-1:0] right_w;

		assign ctl[k] = '{
			op:    acc ? op_d : OP_HOLD,
			at:    (pos_d == POS),
			above: (pos_d < POS),
			rd:    rd_en_d && (rd_addr_d == POS)
		};

		if (k == 0) begin : g_first
			assign left_w = req.value;
		end else begin : g_mid_l
			assign left_w = cell_data[k-1];
		end

		if (k == DEPTH - 1) begin : g_last
			assign right_w = cell_data[k];
		end else begin : g_mid_r
			assign right_w = cell_data[k+1];
		end

		ola_cell u_cell (
			.clk   (clk),
			.ctl   (ctl[k]),
			.value (req.value),
			.left  (left_w),
			.right (right_w),
			.data  (cell_data[k]),
			.hit   (cell_hit[k])
		);
	end

	// Read words are captured at the accept edge, before the shift lands.
	ola_rdtree #(
		.DEPTH (DEPTH)
	) u_rdtree (
		.clk  (clk),
		.load (acc),
		.hit  (cell_hit),
		.word (tree_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			s1_vld_q  <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (acc) begin
				count_q <= cnt_d;
			end
			if (acc) begin
				s1_vld_q <= 1'b1;
			end else if (advance) begin
				s1_vld_q <= 1'b0;
			end
			if (advance) begin
				rsp_vld_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	// beat payload, no reset needed
	always_ff @(posedge clk) begin
		if (acc) begin
			status_s1 <= status_d;
			count_s1  <= cnt_x[CNTW-1:0];
		end
		if (advance) begin
			rsp_q.read_value <= tree_word;
			rsp_q.status     <= status_s1;
			rsp_q.count      <= count_s1;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

	// count never exceeds the depth
	a_count_bound : assert property (@(posedge clk) disable iff (!arst_n)
		XW'(count_q) <= XW'(DEPTH))
		else $error("element count beyond depth");

	// the count moves only with an accepted request
	a_count_hold : assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> $stable(count_q))
		else $error("element count changed without a request");

	// a successful push grows the list by one
	a_push_grow : assert property (@(posedge clk) disable iff (!arst_n)
		acc && (req.kind == KIND_PUSH) && !full |=> count_q == $past(count_q) + CW'(1))
		else $error("push did not grow the list");

	// a read stage blocked behind a stalled result keeps its beat
	a_s1_hold : assert property (@(posedge clk) disable iff (!arst_n)
		s1_vld_q && rsp_vld_q && rsp_stall |=> s1_vld_q)
		else $error("read stage lost a beat");

	// a new result only comes from the read stage
	a_rsp_src : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_vld_q) |-> $past(s1_vld_q))
		else $error("result appeared without a read stage beat");

endmodule

`default_nettype wire
